[rtl/core/dspq_pkg.sv]
// Package for the date-sorted priority queue: capacity, entry layout and codes.
// Used by dspq_cell and date_sorted_priority_queue_unit; depends on nothing.
`default_nettype none

package dspq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int TAG_W   = 16;
    localparam int ENTRY_W = DAY_W + MONTH_W + YEAR_W + TAG_W;
    localparam int DATA_W  = ((ENTRY_W + 7) / 8) * 8;

    // Day sits in the lowest bits, tag in the highest.
    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } t_entry;

    typedef enum logic [1:0] {
        ACT_PUSH = 2'd0,
        ACT_POP  = 2'd1,
        ACT_DUMP = 2'd2,
        ACT_NONE = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_PUSH,
        CMD_POP,
        CMD_ROT
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd cmd;
        logic      occ;   // cell holds a live entry
        logic      wrap;  // cell is the last live one: takes the head on rotate
    } t_cell_ctl;

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } t_state;

    // Key year*10000 + month*100 + day orders exactly as (year, month, day)
    // taken lexicographically, since day < 100 and month*100 + day < 10000.
    function automatic logic date_less(input t_entry a, input t_entry b);
        return {a.year, a.month, a.day} < {b.year, b.month, b.day};
    endfunction

endpackage

`default_nettype wire

[rtl/core/dspq_cell.sv]
// One slot of the sorted chain: holds an entry and moves it to a neighbour.
// Depends on dspq_pkg.
`default_nettype none

module dspq_cell (
    input  wire                      i_clk,
    input  wire dspq_pkg::t_cell_ctl i_ctl,
    input  wire dspq_pkg::t_entry    i_new,
    input  wire dspq_pkg::t_entry    i_prev,
    input  wire                      i_prev_ins,
    input  wire dspq_pkg::t_entry    i_next,
    input  wire dspq_pkg::t_entry    i_head,
    output dspq_pkg::t_entry         o_entry,
    output logic                     o_ins
);
    import dspq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // An empty slot, or a later date, means the new entry goes here or before.
    always_comb begin
        o_ins = !i_ctl.occ || date_less(i_new, r_entry);
    end

    always_comb begin
        n_entry = r_entry;
        case (i_ctl.cmd)
            CMD_PUSH: begin
                if (o_ins) begin
                    n_entry = i_prev_ins ? i_prev : i_new;
                end
            end
            CMD_POP:  n_entry = i_next;
            CMD_ROT:  n_entry = i_ctl.wrap ? i_head : i_next;
            default:  n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

[rtl/core/date_sorted_priority_queue_unit.sv]
// Date-sorted priority queue: top level with handshake, control and cell chain.
// Depends on dspq_pkg and dspq_cell.
// The result item of a push or pop appears in the output register
// the cycle after acceptance, and a new item is taken every cycle while the
// output is drained. A dump of n > 0 entries first enters the dump state, then
// streams n result items one per cycle from the head cell while the chain
// rotates and the output is drained; input is held off throughout the dump
// and during any output stall. Synchronous active-low reset clears the
// entry count, the state and the output valid; slot contents are not cleared.
`default_nettype none

module date_sorted_priority_queue_unit (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    // Slave side: tdata = day[4:0], month[8:5], year[22:9], tag[38:23], pad
    input  wire                     i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  wire [dspq_pkg::DATA_W-1:0] i_s_axis_tdata,
    // tuser = action[1:0]
    input  wire [1:0]               i_s_axis_tuser,
    // Master side: tdata = out_day[4:0], out_month[8:5], out_year[22:9],
    // out_tag[38:23], pad
    output logic                    o_m_axis_tvalid,
    input  wire                     i_m_axis_tready,
    output logic [dspq_pkg::DATA_W-1:0] o_m_axis_tdata,
    // tuser = entry_valid[0], status[2:1]
    output logic [2:0]              o_m_axis_tuser,
    output logic                    o_m_axis_tlast
);
    import dspq_pkg::*;

    // Control state
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [IDX_W-1:0]   r_dump_idx, n_dump_idx;

    // Output register
    logic               r_out_valid, n_out_valid;
    t_entry             r_out_entry, n_out_entry;
    logic               r_out_ev, n_out_ev;
    t_status            r_out_status, n_out_status;
    logic               r_out_last, n_out_last;

    logic               out_free;
    logic               accept;
    logic               q_full;
    logic               q_empty;
    logic               dump_last;
    t_action            action;
    t_entry             new_entry;
    t_cell_cmd          cmd;

    t_entry             w_entry [CAPACITY];
    logic               w_ins   [CAPACITY];
    t_cell_ctl          w_ctl   [CAPACITY];

    assign out_free  = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE) && out_free;
    assign accept    = i_s_axis_tvalid && o_s_axis_tready;
    assign action    = t_action'(i_s_axis_tuser);
    assign new_entry = t_entry'(i_s_axis_tdata[ENTRY_W-1:0]);
    assign q_full    = (r_count == CNT_W'(CAPACITY));
    assign q_empty   = (r_count == '0);
    assign dump_last = ((CNT_W'(r_dump_idx) + CNT_W'(1)) == r_count);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && action == ACT_DUMP && !q_empty) begin
                    n_state = S_DUMP;
                end
            end
            S_DUMP: begin
                if (out_free && dump_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs of the controller: chain command, count, dump index, result item
    always_comb begin
        cmd          = CMD_HOLD;
        n_count      = r_count;
        n_dump_idx   = r_dump_idx;
        n_out_valid  = out_free ? 1'b0 : r_out_valid;
        n_out_entry  = r_out_entry;
        n_out_ev     = r_out_ev;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (action)
                        ACT_PUSH: begin
                            n_out_valid  = 1'b1;
                            n_out_entry  = '0;
                            n_out_ev     = 1'b0;
                            n_out_last   = 1'b1;
                            if (q_full) begin
                                // drop the push and flag it
                                n_out_status = ST_FULL;
                            end else begin
                                cmd          = CMD_PUSH;
                                n_count      = r_count + CNT_W'(1);
                                n_out_status = ST_OK;
                            end
                        end
                        ACT_POP: begin
                            n_out_valid = 1'b1;
                            n_out_last  = 1'b1;
                            if (q_empty) begin
                                n_out_entry  = '0;
                                n_out_ev     = 1'b0;
                                n_out_status = ST_EMPTY;
                            end else begin
                                cmd          = CMD_POP;
                                n_count      = r_count - CNT_W'(1);
                                n_out_entry  = w_entry[0];
                                n_out_ev     = 1'b1;
                                n_out_status = ST_OK;
                            end
                        end
                        ACT_DUMP: begin
                            n_dump_idx = '0;
                            if (q_empty) begin
                                n_out_valid  = 1'b1;
                                n_out_entry  = '0;
                                n_out_ev     = 1'b0;
                                n_out_status = ST_EMPTY;
                                n_out_last   = 1'b1;
                            end
                        end
                        default: begin
                            // unused code: swallow the item, no result
                        end
                    endcase
                end
            end
            S_DUMP: begin
                // emit the head, rotate the live entries by one
                if (out_free) begin
                    cmd          = CMD_ROT;
                    n_dump_idx   = r_dump_idx + IDX_W'(1);
                    n_out_valid  = 1'b1;
                    n_out_entry  = w_entry[0];
                    n_out_ev     = 1'b1;
                    n_out_status = ST_OK;
                    n_out_last   = dump_last;
                end
            end
            default: begin
                cmd = CMD_HOLD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_dump_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dump_idx  <= n_dump_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_entry  <= n_out_entry;
        r_out_ev     <= n_out_ev;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    // Cell chain: entry 0 is the head (earliest date)
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign w_ctl[g].cmd  = cmd;
        assign w_ctl[g].occ  = (r_count > CNT_W'(g));
        assign w_ctl[g].wrap = (r_count == CNT_W'(g + 1));

        dspq_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl[g]),
            .i_new      (new_entry),
            .i_prev     ((g == 0) ? new_entry : w_entry[(g == 0) ? 0 : g - 1]),
            .i_prev_ins ((g == 0) ? 1'b0 : w_ins[(g == 0) ? 0 : g - 1]),
            .i_next     ((g == CAPACITY - 1) ? t_entry'('0)
                                             : w_entry[(g == CAPACITY - 1) ? g : g + 1]),
            .i_head     (w_entry[0]),
            .o_entry    (w_entry[g]),
            .o_ins      (w_ins[g])
        );
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = DATA_W'(r_out_entry);
    assign o_m_axis_tuser  = {r_out_status, r_out_ev};
    assign o_m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire
